// ----- hw/rtl/jmss_pkg.sv -----
package jmss_pkg;

  localparam int unsigned POS_BITS_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [15:0] BUDGET_RESET   = 16'd8192;

  localparam logic [1:0] EV_FRAME   = 2'd0;
  localparam logic [1:0] EV_EXIF    = 2'd1;
  localparam logic [1:0] EV_SUMMARY = 2'd2;

  localparam logic [2:0] ST_SOS       = 3'd0;
  localparam logic [2:0] ST_EOI       = 3'd1;
  localparam logic [2:0] ST_ENDED     = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_BUDGET    = 3'd5;
  localparam logic [2:0] ST_NOT_JPEG  = 3'd6;

  localparam logic [7:0] MK_FF  = 8'hFF;
  localparam logic [7:0] MK_SOI = 8'hD8;
  localparam logic [7:0] MK_EOI = 8'hD9;
  localparam logic [7:0] MK_SOS = 8'hDA;
  localparam logic [7:0] MK_APP0 = 8'hE0;
  localparam logic [7:0] MK_APP1 = 8'hE1;
  localparam logic [7:0] MK_DHT = 8'hC4;
  localparam logic [7:0] MK_JPG = 8'hC8;
  localparam logic [7:0] MK_DAC = 8'hCC;
  localparam logic [7:0] MK_TEM = 8'h01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_ff;
    logic       is_skip;
    logic       is_eoi;
  } byte_cls_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [3:0]  sof_number;
    logic [31:0] exif_offset;
    logic [2:0]  end_status;
    logic [31:0] total_bytes;
    logic        jfif_seen;
    logic [7:0]  jfif_major;
    logic [7:0]  jfif_minor;
    logic        xmp_seen;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic      ev_v;
    out_item_t ev;
    logic      sum_v;
    out_item_t sum;
  } pair_t;

  function automatic logic [7:0] exif_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h78;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h66;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] jfif_char(input logic [2:0] i, input logic xx);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'h4A;
      3'd1:    c = 8'h46;
      3'd2:    c = xx ? 8'h58 : 8'h49;
      3'd3:    c = xx ? 8'h58 : 8'h46;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] xmp_char(input logic [4:0] i);
    logic [7:0] c;
    unique case (i)
      5'd0:  c = 8'h68; 5'd1:  c = 8'h74; 5'd2:  c = 8'h74; 5'd3:  c = 8'h70;
      5'd4:  c = 8'h3A; 5'd5:  c = 8'h2F; 5'd6:  c = 8'h2F; 5'd7:  c = 8'h6E;
      5'd8:  c = 8'h73; 5'd9:  c = 8'h2E; 5'd10: c = 8'h61; 5'd11: c = 8'h64;
      5'd12: c = 8'h6F; 5'd13: c = 8'h62; 5'd14: c = 8'h65; 5'd15: c = 8'h2E;
      5'd16: c = 8'h63; 5'd17: c = 8'h6F; 5'd18: c = 8'h6D; 5'd19: c = 8'h2F;
      5'd20: c = 8'h78; 5'd21: c = 8'h61; 5'd22: c = 8'h70; 5'd23: c = 8'h2F;
      5'd24: c = 8'h31; 5'd25: c = 8'h2E; 5'd26: c = 8'h30; 5'd27: c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/jmss_fifo.sv -----
module jmss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end
endmodule

// ----- hw/rtl/jmss_front.sv -----
module jmss_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  jmss_pkg::in_item_t   in_item,
  output logic                 in_full,
  input  logic                 cls_pop,
  output jmss_pkg::byte_cls_t  cls,
  output logic                 cls_empty
);
  import jmss_pkg::*;

  byte_cls_t cls_in;
  logic [7:0] b;

  // byte classes the scanner needs in the marker hunt
  always_comb begin
    b = in_item.data_byte;
    cls_in.data_byte = b;
    cls_in.last_byte = in_item.last_byte;
    cls_in.is_ff     = (b == MK_FF);
    cls_in.is_skip   = (b == 8'h00) || (b == MK_SOI) || (b == MK_TEM) ||
                       (b[7:3] == 5'b11010);
    cls_in.is_eoi    = (b == MK_EOI);
  end

  jmss_fifo #(.WIDTH($bits(byte_cls_t)), .DEPTH(QUEUE_DEPTH)) u_q (
    .clk, .rst_n,
    .push(in_push), .din(cls_in), .full(in_full),
    .pop(cls_pop), .dout(cls), .empty(cls_empty)
  );
endmodule

// ----- hw/rtl/jmss_engine.sv -----
module jmss_engine #(
  parameter int unsigned POS_BITS = jmss_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         budget,
  input  jmss_pkg::byte_cls_t cls,
  input  logic                cls_empty,
  output logic                cls_pop,
  output logic                pair_push,
  output jmss_pkg::pair_t     pair,
  input  logic                pair_full
);
  import jmss_pkg::*;

  typedef enum logic [2:0] {
    SOI0, SOI1, HUNT, FILL, LEN_HI, LEN_LO, PAYLOAD, STOPPED
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]         passes_r, passes_nxt;
  logic [7:0]          marker_r, marker_nxt;
  logic [15:0]         rem_r, rem_nxt;
  logic [15:0]         pidx_r, pidx_nxt;
  logic [3:0]          sig_r, sig_nxt;
  logic [15:0]         hh_r, hh_nxt, hw_r, hw_nxt, hv_r, hv_nxt;
  logic [15:0]         jv_r, jv_nxt;
  logic [2:0]          found_r, found_nxt;
  logic [2:0]          endc_r, endc_nxt;

  logic                take, fin, last, is_sof;
  logic [7:0]          b;
  logic [15:0]         len, flen;
  logic [POS_BITS-1:0] off_w, tot_w;
  logic [2:0]          code;

  assign take    = !cls_empty && !pair_full;
  assign cls_pop = take;

  always_comb begin
    mode_nxt = mode_r;   pos_nxt = pos_r;     passes_nxt = passes_r;
    marker_nxt = marker_r; rem_nxt = rem_r;   pidx_nxt = pidx_r;
    sig_nxt = sig_r;     hh_nxt = hh_r;       hw_nxt = hw_r;
    hv_nxt = hv_r;       jv_nxt = jv_r;       found_nxt = found_r;
    endc_nxt = endc_r;
    pair = '0;
    fin = 1'b0;
    flen = '0;
    len = '0;
    code = ST_ENDED;
    b = cls.data_byte;
    last = cls.last_byte;
    is_sof = (marker_r[7:4] == 4'hC) && (marker_r != MK_DHT) &&
             (marker_r != MK_JPG) && (marker_r != MK_DAC);
    off_w = '0;
    tot_w = pos_r + POS_BITS'(1);

    if (take) begin
      unique case (mode_r)
        SOI0: begin
          if (!cls.is_ff) begin
            mode_nxt = STOPPED; endc_nxt = ST_NOT_JPEG;
          end else begin
            mode_nxt = SOI1;
          end
        end
        SOI1: begin
          if (b != MK_SOI) begin
            mode_nxt = STOPPED; endc_nxt = ST_NOT_JPEG;
          end else begin
            mode_nxt = HUNT;
          end
        end
        HUNT: begin
          if (!last) begin
            if (passes_r == '0) begin
              mode_nxt = STOPPED; endc_nxt = ST_BUDGET;
            end else begin
              passes_nxt = passes_r - 16'd1;
              if (cls.is_ff) mode_nxt = FILL;
            end
          end
        end
        FILL: begin
          if (!cls.is_ff) begin
            marker_nxt = b;
            if (cls.is_skip) begin
              mode_nxt = HUNT;
            end else if (cls.is_eoi) begin
              mode_nxt = STOPPED; endc_nxt = ST_EOI;
            end else if (last) begin
              mode_nxt = STOPPED; endc_nxt = ST_TRUNCATED;
            end else begin
              mode_nxt = LEN_HI;
            end
          end
        end
        LEN_HI: begin
          rem_nxt = {b, 8'h00};
          if (last) begin
            mode_nxt = STOPPED; endc_nxt = ST_TRUNCATED;
          end else begin
            mode_nxt = LEN_LO;
          end
        end
        LEN_LO: begin
          len = {rem_r[15:8], b};
          if (len < 16'd2) begin
            mode_nxt = STOPPED; endc_nxt = ST_BAD_LEN;
          end else if (len == 16'd2) begin
            pidx_nxt = '0; sig_nxt = '0; fin = 1'b1;
          end else if (last) begin
            mode_nxt = STOPPED; endc_nxt = ST_TRUNCATED;
          end else begin
            rem_nxt = len - 16'd2; pidx_nxt = '0; sig_nxt = 4'hF;
            mode_nxt = PAYLOAD;
          end
        end
        PAYLOAD: begin
          // signature tracking and header field capture
          if (pidx_r < 16'd6 && b != exif_char(pidx_r[2:0])) sig_nxt[0] = 1'b0;
          if (pidx_r < 16'd29 && b != xmp_char(pidx_r[4:0])) sig_nxt[1] = 1'b0;
          if (pidx_r < 16'd5 && b != jfif_char(pidx_r[2:0], 1'b0)) sig_nxt[2] = 1'b0;
          if (pidx_r < 16'd5 && b != jfif_char(pidx_r[2:0], 1'b1)) sig_nxt[3] = 1'b0;
          if (pidx_r == 16'd1) hh_nxt[15:8] = b;
          if (pidx_r == 16'd2) hh_nxt[7:0]  = b;
          if (pidx_r == 16'd3) hw_nxt[15:8] = b;
          if (pidx_r == 16'd4) hw_nxt[7:0]  = b;
          if (pidx_r == 16'd5) hv_nxt[15:8] = b;
          if (pidx_r == 16'd6) hv_nxt[7:0]  = b;
          pidx_nxt = pidx_r + 16'd1;
          rem_nxt  = rem_r - 16'd1;
          if (rem_nxt == '0) begin
            fin = 1'b1;
          end else if (last) begin
            mode_nxt = STOPPED; endc_nxt = ST_TRUNCATED;
          end
        end
        default: mode_nxt = STOPPED;
      endcase

      if (fin) begin
        flen  = pidx_nxt;
        off_w = pos_r + POS_BITS'(7) - POS_BITS'(flen);
        if (is_sof) begin
          if (flen >= 16'd5) begin
            pair.ev_v = 1'b1;
            pair.ev.event_kind   = EV_FRAME;
            pair.ev.frame_height = hh_nxt;
            pair.ev.frame_width  = hw_nxt;
            pair.ev.sof_number   = marker_r[3:0];
            pair.ev.last_of_run  = !last;
          end
        end else if (marker_r == MK_APP1 && flen >= 16'd6 && sig_nxt[0]) begin
          pair.ev_v = 1'b1;
          pair.ev.event_kind  = EV_EXIF;
          pair.ev.exif_offset = 32'(off_w);
          pair.ev.last_of_run = !last;
        end else if (marker_r == MK_APP1 && flen >= 16'd29 && sig_nxt[1]) begin
          found_nxt[1] = 1'b1;
        end else if (marker_r == MK_APP0 && flen >= 16'd7 && sig_nxt[2]) begin
          found_nxt = found_nxt | 3'b101;
          jv_nxt = hv_nxt;
        end else if (marker_r == MK_APP0 && flen >= 16'd6 && sig_nxt[3]) begin
          found_nxt[0] = 1'b1;
        end
        if (marker_r == MK_SOS) begin
          mode_nxt = STOPPED; endc_nxt = ST_SOS;
        end else begin
          mode_nxt = HUNT;
        end
      end

      if (last) begin
        code = (mode_nxt == STOPPED) ? endc_nxt : ST_ENDED;
        if (pos_r < POS_BITS'(3)) code = ST_NOT_JPEG;
        pair.sum_v = 1'b1;
        pair.sum.event_kind  = EV_SUMMARY;
        pair.sum.end_status  = code;
        pair.sum.total_bytes = 32'(tot_w);
        pair.sum.jfif_seen   = found_nxt[0];
        pair.sum.jfif_major  = found_nxt[2] ? jv_nxt[15:8] : 8'd1;
        pair.sum.jfif_minor  = found_nxt[2] ? jv_nxt[7:0] : 8'd0;
        pair.sum.xmp_seen    = found_nxt[1];
        pair.sum.last_of_run = 1'b1;
        // new file starts with the next byte
        mode_nxt = SOI0;  pos_nxt = '0;   passes_nxt = budget;
        marker_nxt = '0;  rem_nxt = '0;   pidx_nxt = '0;  sig_nxt = '0;
        hh_nxt = '0; hw_nxt = '0; hv_nxt = '0; jv_nxt = '0;
        found_nxt = '0;   endc_nxt = ST_SOS;
      end else begin
        pos_nxt = tot_w;
      end
    end
  end

  assign pair_push = take && (pair.ev_v || pair.sum_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= SOI0;   pos_r <= '0;   passes_r <= BUDGET_RESET;
      marker_r <= '0;   rem_r <= '0;   pidx_r <= '0;  sig_r <= '0;
      hh_r <= '0; hw_r <= '0; hv_r <= '0; jv_r <= '0;
      found_r <= '0;    endc_r <= ST_SOS;
    end else begin
      mode_r <= mode_nxt;     pos_r <= pos_nxt;   passes_r <= passes_nxt;
      marker_r <= marker_nxt; rem_r <= rem_nxt;   pidx_r <= pidx_nxt;
      sig_r <= sig_nxt;       hh_r <= hh_nxt;     hw_r <= hw_nxt;
      hv_r <= hv_nxt;         jv_r <= jv_nxt;     found_r <= found_nxt;
      endc_r <= endc_nxt;
    end
  end
endmodule

// ----- hw/rtl/jmss_drain.sv -----
module jmss_drain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pair_push,
  input  jmss_pkg::pair_t     pair,
  output logic                pair_full,
  output logic                out_empty,
  input  logic                out_pop,
  output jmss_pkg::out_item_t out_item
);
  import jmss_pkg::*;

  pair_t head;
  logic  head_pop, phase_r, phase_nxt, both;

  assign both      = head.ev_v && head.sum_v;
  assign out_item  = (head.ev_v && !phase_r) ? head.ev : head.sum;
  assign head_pop  = out_pop && !out_empty && !(both && !phase_r);

  always_comb begin
    phase_nxt = phase_r;
    if (out_pop && !out_empty) phase_nxt = !head_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  jmss_fifo #(.WIDTH($bits(pair_t)), .DEPTH(QUEUE_DEPTH)) u_q (
    .clk, .rst_n,
    .push(pair_push), .din(pair), .full(pair_full),
    .pop(head_pop), .dout(head), .empty(out_empty)
  );
endmodule

// ----- hw/rtl/jpeg_marker_segment_scanner.sv -----
// a byte is registered in the input queue, scanned from the queue head, and its
// results are registered in the result queue, from which out_item is read
// throughput: one byte per cycle while the result queue has room;
// a byte that ends a file after a finished segment gives two results, drained one per pop
// reset: synchronous active-low rst_n empties both queues, restarts the scan and
// sets scan_budget to 8192
module jpeg_marker_segment_scanner #(
  parameter int unsigned POS_BITS = jmss_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // byte input queue
  input  logic                in_push,
  input  jmss_pkg::in_item_t  in_item,
  output logic                in_full,
  // result queue
  output logic                out_empty,
  input  logic                out_pop,
  output jmss_pkg::out_item_t out_item,
  // scan budget register write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_scan_budget
);
  import jmss_pkg::*;

  logic [15:0] budget_r;
  byte_cls_t   cls;
  logic        cls_empty, cls_pop;
  pair_t       pair;
  logic        pair_push, pair_full;

  // config writes are always accepted and registered into budget_r
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_valid) begin
      budget_r <= cfg_scan_budget;
    end
  end

  // front: takes bytes, tags marker-hunt classes, queues them
  jmss_front u_front (
    .clk, .rst_n,
    .in_push, .in_item, .in_full,
    .cls_pop, .cls, .cls_empty
  );

  // scanner: one byte per cycle whenever a byte is queued and the result queue has room
  jmss_engine #(.POS_BITS(POS_BITS)) u_engine (
    .clk, .rst_n,
    .budget(budget_r),
    .cls, .cls_empty, .cls_pop,
    .pair_push, .pair, .pair_full
  );

  // back: result pairs queued and handed out one transaction at a time
  jmss_drain u_drain (
    .clk, .rst_n,
    .pair_push, .pair, .pair_full,
    .out_empty, .out_pop, .out_item
  );
endmodule
